>>> src/temporal_pixel_accumulator_defines.svh
// ----------------------------------------------------------------------------
// temporal pixel accumulator assertion macros
// shared concurrent check forms, clocked on the rising edge, off during reset
// ----------------------------------------------------------------------------
`ifndef TEMPORAL_PIXEL_ACCUMULATOR_DEFINES_SVH
`define TEMPORAL_PIXEL_ACCUMULATOR_DEFINES_SVH

// same-cycle implication
`define TPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpa: same-cycle check failed");

// next-cycle implication
`define TPA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpa: next-cycle check failed");

`endif

>>> src/tpa_pkg.sv
// ----------------------------------------------------------------------------
// tpa_pkg
// widths, codes and constant tables of the temporal pixel accumulator
// ----------------------------------------------------------------------------
package tpa_pkg;

    localparam int MAX_WIDTH   = 256;
    localparam int MAX_HEIGHT  = 256;
    localparam int CHAN_W      = 24;
    localparam int ADDR_W      = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int CNT_W       = 16;
    localparam int XY_W        = 8;
    localparam int DIM_W       = 9;
    localparam int SCALE_W     = 12;
    localparam int WT_W        = 16;
    localparam int LP_W        = WT_W + CHAN_W;
    localparam int HP_W        = CHAN_W + 19;
    localparam int SC_W        = SCALE_W + CHAN_W;
    localparam int LIM_W       = 29;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    // reciprocal rom of the bias correction
    localparam int RECIP_W     = 19;
    localparam int RECIP_DEPTH = 64;
    localparam int RECIP_IDX_W = 6;

    // pipeline shape: front stages, then one divider step per quotient bit
    localparam int PRE_STAGES  = 10;
    localparam int DIV_STEPS   = CHAN_W;
    localparam int NSTG        = PRE_STAGES + DIV_STEPS;

    localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

    // luma weights in UQ0.16, red first
    localparam logic [2:0][WT_W-1:0] LUMA_WT = {16'd4732, 16'd46871, 16'd13933};

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_FLOOR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_BIAS   = 3'd4;

    // item operations
    typedef enum logic [1:0] {
        OP_ACC = 2'd0,
        OP_RES = 2'd1,
        OP_CLR = 2'd2
    } t_op;

    typedef logic [2:0][CHAN_W-1:0] t_rgb;

    // control and state that travel with every beat
    typedef struct packed {
        logic              vld;
        t_op               op;
        logic [ADDR_W-1:0] addr;
        logic [CNT_W-1:0]  cnt;
        t_rgb              hist;
    } t_meta;

    typedef logic [RECIP_DEPTH-1:0][RECIP_W-1:0] t_recip_rom;

    // entry n >= 1 is round(2^48 / (2^32 - p_n)), p_n = floor(3/4 p_(n-1)), p_0 = 2^32; entry 0 = entry 1
    function automatic t_recip_rom build_recip();
        t_recip_rom  rom;
        logic [63:0] p;
        logic [63:0] d;
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] q;
        int          nn;
        rom = '0;
        for (int n = 0; n < RECIP_DEPTH; n++) begin
            nn = (n == 0) ? 1 : n;
            p  = 64'd1 << 32;
            for (int i = 0; i < nn; i++) begin
                p = (p * 64'd3) >> 2;
            end
            d   = (64'd1 << 32) - p;
            num = (64'd1 << 48) + (d >> 1);
            rem = '0;
            q   = '0;
            for (int b = 48; b >= 0; b--) begin
                rem = {rem[62:0], num[b]};
                if (rem >= d) begin
                    rem  = rem - d;
                    q[b] = 1'b1;
                end
            end
            rom[n] = q[RECIP_W-1:0];
        end
        return rom;
    endfunction

    localparam t_recip_rom RECIP_ROM = build_recip();

endpackage

>>> src/tpa_in_if.sv
// ----------------------------------------------------------------------------
// tpa_in_if
// input channel: one accumulate, resolve or clear item per beat
// ----------------------------------------------------------------------------
interface tpa_in_if
    import tpa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [XY_W-1:0]   pos_x;
    logic [XY_W-1:0]   pos_y;
    logic              mask_bit;
    logic [CHAN_W-1:0] sample_red;
    logic [CHAN_W-1:0] sample_green;
    logic [CHAN_W-1:0] sample_blue;

    modport source (
        output valid, mode, pos_x, pos_y, mask_bit, sample_red, sample_green, sample_blue,
        input  ready
    );
    modport sink (
        input  valid, mode, pos_x, pos_y, mask_bit, sample_red, sample_green, sample_blue,
        output ready
    );
endinterface

>>> src/tpa_out_if.sv
// ----------------------------------------------------------------------------
// tpa_out_if
// result channel: one resolved pixel per beat
// ----------------------------------------------------------------------------
interface tpa_out_if
    import tpa_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] resolved_red;
    logic [CHAN_W-1:0] resolved_green;
    logic [CHAN_W-1:0] resolved_blue;
    logic [CNT_W-1:0]  samples_seen;

    modport source (
        output valid, resolved_red, resolved_green, resolved_blue, samples_seen,
        input  ready
    );
    modport sink (
        input  valid, resolved_red, resolved_green, resolved_blue, samples_seen,
        output ready
    );
endinterface

>>> src/temporal_pixel_accumulator.sv
// ----------------------------------------------------------------------------
// temporal_pixel_accumulator
// per-pixel rgb ema with saturating sample count, luma clamp and bias-corrected
// resolve, as a 34-stage pipeline around a 64k-entry pixel store
// ----------------------------------------------------------------------------
// usage:
//  i_in carries accumulate, resolve and clear beats; o_out carries one result
//  beat per in-frame resolve. the write port i_cfg_* sets the frame size and
//  the clamp; write it only while no beat is in flight.
//  an item writes the store, or raises o_out.valid with its result, after
//  ten front stages (address, store read, reciprocal, history, luma, clamp
//  limit) and 24 restoring divider steps, one quotient bit per stage.
//  throughput is one item per cycle while no interlock, sweep or output hold
//  stalls entry. an item whose pixel has an accumulate or clear still in the
//  pipeline waits until that item has written the store; this read-modify-write
//  interlock sets the rate for repeated pixels.
//  after reset the count store is swept to zero, one entry per cycle, with
//  i_in.ready low; config writes are taken during the sweep.
//  out-of-frame items, masked accumulates and mode 3 are dropped at entry.
//  a result waits in the output register while o_out.ready is low; the
//  pipeline keeps moving and only holds when a second result reaches the end.
// ----------------------------------------------------------------------------
`include "temporal_pixel_accumulator_defines.svh"

module temporal_pixel_accumulator
    import tpa_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tpa_in_if.sink                i_in,
    tpa_out_if.source             o_out
);

    // configuration registers
    logic [DIM_W-1:0]   r_width;
    logic [DIM_W-1:0]   r_height;
    logic [SCALE_W-1:0] r_scale;
    logic [CHAN_W-1:0]  r_floor;
    logic [CHAN_W-1:0]  r_bias;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= MAX_W_DIM;
            r_height <= MAX_H_DIM;
            r_scale  <= SCALE_W'(768);
            r_floor  <= CHAN_W'(65536);
            r_bias   <= CHAN_W'(16384);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_WIDTH:  r_width  <= i_cfg_data[DIM_W-1:0];
                CFG_FRAME_HEIGHT: r_height <= i_cfg_data[DIM_W-1:0];
                CFG_CLAMP_SCALE:  r_scale  <= i_cfg_data[SCALE_W-1:0];
                CFG_CLAMP_FLOOR:  r_floor  <= i_cfg_data[CHAN_W-1:0];
                CFG_CLAMP_BIAS:   r_bias   <= i_cfg_data[CHAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // pipeline registers
    t_meta              r_meta [NSTG];
    t_rgb               r_smp [9];
    logic [2:0][LP_W-1:0] r_sp;
    logic [CHAN_W-1:0]  r_sl [7];
    logic [RECIP_W-1:0] r_recip;
    logic [2:0][HP_W-1:0] r_hp;
    t_rgb               r_h [5];
    logic [2:0][LP_W-1:0] r_lp;
    logic [CHAN_W-1:0]  r_hl;
    logic [SC_W-1:0]    r_sc;
    logic [LIM_W-1:0]   r_lim;
    t_rgb               r_dv_rem [DIV_STEPS+1];
    t_rgb               r_dv_work [DIV_STEPS+1];
    logic [CHAN_W-1:0]  r_dv_div [DIV_STEPS+1];

    // store and sweep
    logic [CNT_W-1:0]    r_count_mem [STORE_DEPTH];
    t_rgb                r_hist_mem [STORE_DEPTH];
    logic [CNT_W-1:0]    r_rd_cnt;
    t_rgb                r_rd_hist;
    logic                r_clr_busy;
    logic [ADDR_W-1:0]   r_clr_addr;

    // output register
    logic                r_out_vld;
    t_rgb                r_out_rgb;
    logic [CNT_W-1:0]    r_out_cnt;

    // entry checks and address
    logic [DIM_W-1:0]  w_eff;
    logic [DIM_W-1:0]  h_eff;
    logic [ADDR_W:0]   addr_full;
    logic [ADDR_W-1:0] in_addr;
    logic              in_frame;
    logic              in_op_ok;
    logic              hazard;
    logic              adv;
    logic              in_ready;
    logic              in_take;
    t_meta             w_meta;
    logic              wb_we;
    logic              any_vld;

    assign w_eff     = (r_width > MAX_W_DIM) ? MAX_W_DIM : r_width;
    assign h_eff     = (r_height > MAX_H_DIM) ? MAX_H_DIM : r_height;
    assign addr_full = (ADDR_W+1)'(i_in.pos_y) * (ADDR_W+1)'(w_eff)
                     + (ADDR_W+1)'(i_in.pos_x);
    assign in_addr   = addr_full[ADDR_W-1:0];
    assign in_frame  = ({1'b0, i_in.pos_x} < w_eff) && ({1'b0, i_in.pos_y} < h_eff);
    assign in_op_ok  = ((i_in.mode == OP_ACC) && i_in.mask_bit) || (i_in.mode == OP_RES)
                     || (i_in.mode == OP_CLR);

    // read-modify-write interlock against writers in flight
    always_comb begin
        hazard  = 1'b0;
        any_vld = 1'b0;
        for (int s = 0; s < NSTG; s++) begin
            if (r_meta[s].vld && (r_meta[s].op != OP_RES) && (r_meta[s].addr == in_addr))
                hazard = 1'b1;
            if (r_meta[s].vld)
                any_vld = 1'b1;
        end
    end

    assign w_meta   = r_meta[NSTG-1];
    assign adv      = !(r_out_vld && !o_out.ready && w_meta.vld && (w_meta.op == OP_RES));
    assign in_ready = adv && !r_clr_busy && !hazard;
    assign in_take  = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    // stage combinational terms
    logic [LP_W+1:0]  sl_sum;
    logic [RECIP_IDX_W-1:0] ridx;
    t_rgb             n_h;
    logic [LP_W+1:0]  hl_sum;
    logic [SC_W:0]    sc_rnd;
    logic [LIM_W-1:0] lim_raw;
    logic             use_div;
    t_rgb             n_rem0;
    t_rgb             n_work0;
    logic [CHAN_W-1:0] n_div0;
    t_rgb             n_dv_rem [DIV_STEPS+1];
    t_rgb             n_dv_work [DIV_STEPS+1];

    always_comb begin
        logic [HP_W:0]         hv;
        logic [2*CHAN_W:0]     num;
        logic [CHAN_W-1:0]     sel;
        logic [CHAN_W:0]       t;

        // sample luma, reciprocal index
        sl_sum = (LP_W+2)'(r_sp[0]) + (LP_W+2)'(r_sp[1]) + (LP_W+2)'(r_sp[2])
               + (LP_W+2)'(32768);
        ridx   = (r_rd_cnt > CNT_W'(RECIP_DEPTH-1)) ? '1 : r_rd_cnt[RECIP_IDX_W-1:0];

        // bias-corrected history with saturation
        for (int k = 0; k < 3; k++) begin
            hv     = {1'b0, r_hp[k]} + (HP_W+1)'(32768);
            n_h[k] = (|hv[HP_W:CHAN_W+16]) ? '1 : hv[CHAN_W+15:16];
        end

        // history luma and clamp limit
        hl_sum  = (LP_W+2)'(r_lp[0]) + (LP_W+2)'(r_lp[1]) + (LP_W+2)'(r_lp[2])
                + (LP_W+2)'(32768);
        sc_rnd  = {1'b0, r_sc} + (SC_W+1)'(128);
        lim_raw = LIM_W'(sc_rnd[SC_W:8]) + LIM_W'(r_bias);
        if (lim_raw < LIM_W'(r_floor))
            lim_raw = LIM_W'(r_floor);

        // divider load: clamped accumulate divides, everything else passes by 1
        use_div = (r_meta[8].op == OP_ACC) && (r_meta[8].cnt != '0)
                && (LIM_W'(r_sl[6]) > r_lim);
        n_div0  = use_div ? r_sl[6] : CHAN_W'(1);
        for (int k = 0; k < 3; k++) begin
            if (r_meta[8].op == OP_RES)
                sel = (r_meta[8].cnt == '0) ? '0 : r_h[4][k];
            else
                sel = r_smp[8][k];
            if (use_div)
                num = (2*CHAN_W+1)'(r_smp[8][k] * r_lim[CHAN_W-1:0])
                    + (2*CHAN_W+1)'(r_sl[6] >> 1);
            else
                num = (2*CHAN_W+1)'(sel);
            n_rem0[k]  = num[2*CHAN_W-1:CHAN_W];
            n_work0[k] = num[CHAN_W-1:0];
        end

        // restoring divider steps
        n_dv_rem[0]  = n_rem0;
        n_dv_work[0] = n_work0;
        for (int j = 1; j <= DIV_STEPS; j++) begin
            for (int k = 0; k < 3; k++) begin
                t = {r_dv_rem[j-1][k], r_dv_work[j-1][k][CHAN_W-1]};
                if (t >= {1'b0, r_dv_div[j-1]}) begin
                    n_dv_rem[j][k] = CHAN_W'(t - {1'b0, r_dv_div[j-1]});
                    n_dv_work[j][k] = {r_dv_work[j-1][k][CHAN_W-2:0], 1'b1};
                end else begin
                    n_dv_rem[j][k] = t[CHAN_W-1:0];
                    n_dv_work[j][k] = {r_dv_work[j-1][k][CHAN_W-2:0], 1'b0};
                end
            end
        end
    end

    // pipeline valid bits and payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NSTG; s++) begin
                r_meta[s].vld <= 1'b0;
            end
        end else if (adv) begin
            r_meta[0].vld <= in_take && in_frame && in_op_ok;
            for (int s = 1; s < NSTG; s++) begin
                r_meta[s].vld <= r_meta[s-1].vld;
            end
        end
        if (adv) begin
            // entry
            r_meta[0].op   <= t_op'(i_in.mode);
            r_meta[0].addr <= in_addr;
            r_meta[0].cnt  <= '0;
            r_meta[0].hist <= '0;
            r_smp[0]       <= {i_in.sample_blue, i_in.sample_green, i_in.sample_red};
            for (int s = 1; s < NSTG; s++) begin
                r_meta[s].op   <= r_meta[s-1].op;
                r_meta[s].addr <= r_meta[s-1].addr;
                r_meta[s].cnt  <= (s == 2) ? r_rd_cnt : r_meta[s-1].cnt;
                r_meta[s].hist <= (s == 2) ? r_rd_hist : r_meta[s-1].hist;
            end
            for (int s = 1; s < 9; s++) begin
                r_smp[s] <= r_smp[s-1];
            end
            // sample luma products
            for (int k = 0; k < 3; k++) begin
                r_sp[k] <= LP_W'(LUMA_WT[k]) * LP_W'(r_smp[0][k]);
            end
            // sample luma, reciprocal lookup
            r_sl[0]  <= sl_sum[LP_W-1:16];
            for (int s = 1; s < 7; s++) begin
                r_sl[s] <= r_sl[s-1];
            end
            r_recip  <= RECIP_ROM[ridx];
            // history times reciprocal
            for (int k = 0; k < 3; k++) begin
                r_hp[k] <= HP_W'(r_meta[2].hist[k]) * HP_W'(r_recip);
            end
            // history colour
            r_h[0] <= n_h;
            for (int s = 1; s < 5; s++) begin
                r_h[s] <= r_h[s-1];
            end
            // history luma products
            for (int k = 0; k < 3; k++) begin
                r_lp[k] <= LP_W'(LUMA_WT[k]) * LP_W'(r_h[0][k]);
            end
            r_hl  <= hl_sum[LP_W-1:16];
            r_sc  <= SC_W'(r_scale) * SC_W'(r_hl);
            r_lim <= lim_raw;
            // divider
            r_dv_rem[0]  <= n_dv_rem[0];
            r_dv_work[0] <= n_dv_work[0];
            r_dv_div[0]  <= n_div0;
            for (int j = 1; j <= DIV_STEPS; j++) begin
                r_dv_rem[j]  <= n_dv_rem[j];
                r_dv_work[j] <= n_dv_work[j];
                r_dv_div[j]  <= r_dv_div[j-1];
            end
        end
    end

    // write-back values
    t_rgb             wb_hist;
    logic [CNT_W-1:0] wb_cnt;

    always_comb begin
        logic [CHAN_W+2:0] acc;
        logic [CHAN_W:0]   first;
        for (int k = 0; k < 3; k++) begin
            acc   = (CHAN_W+3)'(w_meta.hist[k]) * (CHAN_W+3)'(3)
                  + (CHAN_W+3)'(r_dv_work[DIV_STEPS][k]) + (CHAN_W+3)'(2);
            first = {1'b0, r_dv_work[DIV_STEPS][k]} + (CHAN_W+1)'(2);
            if (w_meta.op == OP_CLR)
                wb_hist[k] = '0;
            else if (w_meta.cnt != '0)
                wb_hist[k] = acc[CHAN_W+1:2];
            else
                wb_hist[k] = CHAN_W'(first[CHAN_W:2]);
        end
        if (w_meta.op == OP_CLR)
            wb_cnt = '0;
        else if (w_meta.cnt == '1)
            wb_cnt = w_meta.cnt;
        else
            wb_cnt = w_meta.cnt + CNT_W'(1);
    end

    assign wb_we = adv && w_meta.vld && (w_meta.op != OP_RES);

    // store: read at entry, written at the last stage or by the sweep
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_rd_cnt  <= r_count_mem[r_meta[0].addr];
            r_rd_hist <= r_hist_mem[r_meta[0].addr];
        end
        if (r_clr_busy) begin
            r_count_mem[r_clr_addr] <= '0;
        end else if (wb_we) begin
            r_count_mem[w_meta.addr] <= wb_cnt;
            r_hist_mem[w_meta.addr]  <= wb_hist;
        end
    end

    // count store sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == '1)
                r_clr_busy <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            if (r_out_vld && o_out.ready)
                r_out_vld <= 1'b0;
            if (adv && w_meta.vld && (w_meta.op == OP_RES))
                r_out_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && w_meta.vld && (w_meta.op == OP_RES)) begin
            r_out_rgb <= r_dv_work[DIV_STEPS];
            r_out_cnt <= w_meta.cnt;
        end
    end

    assign o_out.valid          = r_out_vld;
    assign o_out.resolved_red   = r_out_rgb[0];
    assign o_out.resolved_green = r_out_rgb[1];
    assign o_out.resolved_blue  = r_out_rgb[2];
    assign o_out.samples_seen   = r_out_cnt;

    // checks
    `TPA_ASSERT_IMP(a_sweep_empty, i_clk, i_rst_n, r_clr_busy, !any_vld && !in_ready)
    `TPA_ASSERT_IMP(a_one_writer, i_clk, i_rst_n, r_clr_busy, !wb_we)
    `TPA_ASSERT_NXT(a_res_lands, i_clk, i_rst_n, adv && w_meta.vld && (w_meta.op == OP_RES), r_out_vld)

endmodule
